@@ hdl/double_ended_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Shared forms of the concurrent checks used in the queue control logic.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check that is switched off while reset is held.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also looks at the cycles in and right after reset.
`define DEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Word type, request and result codes, and the command that drives the cells.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // Request actions.
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_PEEK       = 3'd4;
  localparam logic [2:0] ACT_DUMP       = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_HEAD,
    OP_APPEND,
    OP_POP_HEAD,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    value;
  } cell_cmd_t;

endpackage

@@ hdl/deq_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one queue action and its word.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();

  logic       valid;
  logic       ready;
  logic [2:0] action;
  word_t      value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);

endinterface

@@ hdl/deq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result: status, word and last mark.
// ----------------------------------------------------------------------------
interface deq_rsp_if import deq_pkg::*; ();

  logic       valid;
  logic       ready;
  logic [1:0] status;
  word_t      data;
  logic       last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);

endinterface

@@ hdl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// Queue cell
// One entry of the chain. Position IDX counts from the front of the queue.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  cell_cmd_t                    cmd,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  word_t                        prev_data,
  input  word_t                        next_data,
  input  word_t                        head_data,
  output word_t                        data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

  // The entries occupy positions below count; a rotation wraps the front word
  // into the last occupied position.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PUSH_HEAD: data <= prev_data;
      OP_APPEND: begin
        if (IDX_C == count) data <= cmd.value;
      end
      OP_POP_HEAD: data <= next_data;
      OP_ROTATE: begin
        if (NEXT_C < count) begin
          data <= next_data;
        end else if (NEXT_C == count) begin
          data <= head_data;
        end
      end
      default: data <= data;
    endcase
  end

endmodule

@@ hdl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Queue control
// Decodes requests, keeps the entry count and drives the result register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module deq_ctrl import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  deq_req_if.sink                     req,
  deq_rsp_if.source                   rsp,
  input  word_t                       head_data,
  output cell_cmd_t                   cmd,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SEEK, S_DUMP} state_t;

  state_t            state, state_next;
  logic [PTR_W-1:0]  steps, steps_next;
  logic [CNT_W-1:0]  count_next;
  logic              out_valid, out_valid_next;
  logic [1:0]        out_status, out_status_next;
  word_t             out_data, out_data_next;
  logic              out_last, out_last_next;
  logic              out_free, accept, full, empty;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;
  assign rsp.last   = out_last;

  always_comb begin
    state_next      = state;
    steps_next      = steps;
    count_next      = count;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_last_next   = out_last;
    cmd.op          = OP_HOLD;
    cmd.value       = req.value;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.action inside {ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK, ACT_DUMP}
              && empty) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_EMPTY;
            out_data_next   = '0;
            out_last_next   = 1'b1;
          end else begin
            case (req.action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_last_next  = 1'b1;
                if (full) begin
                  out_status_next = ST_FULL;
                end else begin
                  out_status_next = ST_OK;
                  cmd.op     = (req.action == ACT_PUSH_FRONT) ? OP_PUSH_HEAD : OP_APPEND;
                  count_next = count + CNT_W'(1);
                end
              end
              ACT_POP_FRONT: begin
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_data_next   = head_data;
                out_last_next   = 1'b1;
                cmd.op          = OP_POP_HEAD;
                count_next      = count - CNT_W'(1);
              end
              ACT_POP_BACK: begin
                state_next = S_SEEK;
                steps_next = PTR_W'(count - CNT_W'(1));
              end
              ACT_PEEK: begin
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_data_next   = head_data;
                out_last_next   = 1'b1;
              end
              ACT_DUMP: begin
                state_next = S_DUMP;
                steps_next = PTR_W'(count - CNT_W'(1));
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_SEEK: begin
        // Rotate until the back word sits in the front cell, then pop it.
        if (steps != '0) begin
          cmd.op     = OP_ROTATE;
          steps_next = steps - PTR_W'(1);
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_data_next   = head_data;
          out_last_next   = 1'b1;
          cmd.op          = OP_POP_HEAD;
          count_next      = count - CNT_W'(1);
          state_next      = S_IDLE;
        end
      end
      S_DUMP: begin
        // A full turn of the ring streams every entry and restores the order.
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_data_next   = head_data;
          out_last_next   = (steps == '0);
          cmd.op          = OP_ROTATE;
          if (steps == '0) begin
            state_next = S_IDLE;
          end else begin
            steps_next = steps - PTR_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_last   <= out_last_next;
    steps      <= steps_next;
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  `DEQ_ASSERT(a_count_bound, count <= CNT_W'(DEPTH), "entry count above depth")
  `DEQ_ASSERT(a_push_counts, accept && !full && (req.action == ACT_PUSH_FRONT || req.action == ACT_PUSH_BACK) |=> count == $past(count) + CNT_W'(1), "push did not add an entry")
  `DEQ_ASSERT(a_dump_keeps, state == S_DUMP |=> count == $past(count), "dump changed the entry count")
  `DEQ_ASSERT(a_bad_status, out_valid && out_status != ST_OK |-> out_data == '0 && out_last, "error result with data or without last")
  `DEQ_ASSERT_RST(a_reset_idle, rst |=> !out_valid && state == S_IDLE && count == '0, "reset left work pending")

endmodule

@@ hdl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit words held in a chain of DEPTH cells, with
// the front entry always in the first cell.
//
// A request on req carries an action and a word; results leave on rsp.
// Push front, push back, pop front and peek are done when taken and their
// single result sits in the output register on the following cycle, so
// these requests run back to back at one per cycle while rsp keeps up.
// Pop back rotates the chain one position a cycle until the back entry
// reaches the first cell, then pops it. A dump turns the chain once and
// streams count results, one per cycle while rsp keeps up, the final one
// marked with last. A full push or an access to an empty queue gives one
// status result. Reset empties the queue and drops any pending result;
// the cells are not cleared. While rsp stalls, the output register holds
// its result and no further request or step is taken.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  deq_req_if.sink    req,
  deq_rsp_if.source  rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_cmd_t         cmd;
  logic [CNT_W-1:0]  count;
  word_t             cell_data [DEPTH];

  // Control: request decode, entry count, pop-back seek and dump sequencing.
  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .head_data (cell_data[0]),
    .cmd       (cmd),
    .count     (count)
  );

  // The chain: each cell sees its neighbors and the front word, which is
  // what wraps to the tail during a rotation. A push at the front shifts
  // the request word into the first cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t prev_word, next_word;

    if (i == 0) begin : g_first
      assign prev_word = cmd.value;
    end else begin : g_inner_prev
      assign prev_word = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_data[i];
    end else begin : g_inner_next
      assign next_word = cell_data[i+1];
    end

    deq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .prev_data (prev_word),
      .next_data (next_word),
      .head_data (cell_data[0]),
      .data      (cell_data[i])
    );
  end

endmodule

@@ bench/double_ended_queue_tb.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Sends push, pop, peek and dump requests with random gaps on both channels.
// A shadow ring buffer predicts every result. The results are checked in order.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int DEPTH = 64;

  // Action codes that the block has to ignore without a result.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  // Number of counted requests in the random part, the fill burst included.
  localparam int RANDOM_ITEMS = 75;

  // The result side stops taking results for a long stretch once this many
  // requests have gone in. That falls inside the fill burst, so the block
  // backs up and has to stall its request input.
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 200;

  // Slowest correct run: about 110 requests, each with up to 64 results that
  // each wait out the longest random stall, so the limit is set well above it.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

  typedef struct {
    logic [2:0] action;
    word_t      value;
  } deq_request_t;

  typedef struct {
    logic [1:0] status;
    word_t      data;
    logic       last;
  } deq_result_t;

  bit   clk;
  logic rst;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests still to be offered. The initial block fills this queue before
  // the first clock edge.
  deq_request_t pending_requests[$];
  deq_request_t staged;

  // Results predicted but not yet seen on the result channel, oldest first.
  deq_result_t due_results[$];

  // Shadow copy of the ring buffer, updated when a request is accepted.
  word_t shadow_words[DEPTH];
  int    shadow_head;
  int    shadow_fill;

  // Fill level as the generator sees it. The generator uses it only to steer
  // the queue toward a target level.
  int gen_fill;
  int planned_items;

  // Handshake bookkeeping and the figures for the summary.
  bit req_fired;
  bit calm;
  int send_gap;
  int take_gap;
  int hold_left;
  bit hold_done;
  int cycle_count;
  int requests_taken;
  int results_seen;
  int errors;
  int action_hits[8];
  int full_pushes;
  int empty_hits;
  int deepest_dump;
  int input_stalls;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap lengths: most are zero or short and a few are long. While calm is
  // set, both sides run with no gaps at all.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Words lean toward the extremes now and then. The rest are fully random.
  function automatic word_t pick_word();
    case ($urandom_range(11))
      0: return word_t'(32'h7FFF_FFFF);
      1: return word_t'(32'h8000_0000);
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  // Adds one request to the stimulus and tracks the fill level it will leave.
  task automatic plan(logic [2:0] action, word_t value);
    deq_request_t item;
    item.action = action;
    item.value  = value;
    pending_requests.push_back(item);
    if (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK) begin
      if (gen_fill < DEPTH) gen_fill++;
    end else if (action == ACT_POP_FRONT || action == ACT_POP_BACK) begin
      if (gen_fill > 0) gen_fill--;
    end
    if (action <= ACT_DUMP) planned_items++;
  endtask

  function automatic void add_due(logic [1:0] status, word_t data, logic last);
    deq_result_t res;
    res.status = status;
    res.data   = data;
    res.last   = last;
    due_results.push_back(res);
  endfunction

  // Shadow deque. It applies one accepted request and queues the results
  // that the block must give for it.
  function automatic void shadow_apply(logic [2:0] action, word_t value);
    int slot;
    action_hits[action]++;
    case (action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          // The queue is full: the word is dropped and the state is left alone.
          full_pushes++;
          add_due(ST_FULL, '0, 1'b1);
        end else begin
          if (action == ACT_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_words[shadow_head] = value;
          end else begin
            shadow_words[(shadow_head + shadow_fill) % DEPTH] = value;
          end
          shadow_fill++;
          add_due(ST_OK, '0, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK: begin
        if (shadow_fill == 0) begin
          empty_hits++;
          add_due(ST_EMPTY, '0, 1'b1);
        end else begin
          if (action == ACT_POP_BACK) begin
            slot = (shadow_head + shadow_fill - 1) % DEPTH;
            shadow_fill--;
          end else begin
            slot = shadow_head;
            if (action == ACT_POP_FRONT) begin
              shadow_head = (shadow_head + 1) % DEPTH;
              shadow_fill--;
            end
          end
          add_due(ST_OK, shadow_words[slot], 1'b1);
        end
      end
      ACT_DUMP: begin
        if (shadow_fill == 0) begin
          empty_hits++;
          add_due(ST_EMPTY, '0, 1'b1);
        end else begin
          // A dump streams every entry from front to back and leaves them in place.
          for (int i = 0; i < shadow_fill; i++) begin
            add_due(ST_OK, shadow_words[(shadow_head + i) % DEPTH], i == shadow_fill - 1);
          end
          if (shadow_fill > deepest_dump) deepest_dump = shadow_fill;
        end
      end
      default: begin
        // Spare codes cause no result and change no state.
      end
    endcase
  endfunction

  // Compares one accepted result, field by field, with the oldest prediction.
  task automatic check_result();
    deq_result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result: status %0d, data %0d, last %0b", $time,
               rsp_ch.status, rsp_ch.data, rsp_ch.last);
      errors++;
    end else begin
      want = due_results.pop_front();
      if (rsp_ch.status !== want.status) begin
        $display("%0t: result %0d status: expected %0d, actual %0d", $time,
                 results_seen, want.status, rsp_ch.status);
        errors++;
      end
      if (rsp_ch.data !== want.data) begin
        $display("%0t: result %0d data: expected %0d, actual %0d", $time,
                 results_seen, want.data, rsp_ch.data);
        errors++;
      end
      if (rsp_ch.last !== want.last) begin
        $display("%0t: result %0d last: expected %0b, actual %0b", $time,
                 results_seen, want.last, rsp_ch.last);
        errors++;
      end
    end
  endtask

  // Rising edge: both handshakes are sampled here and nothing is driven. A
  // result always belongs to a request that was accepted at an earlier edge,
  // so the order of the check and the prediction within one edge does not
  // matter.
  always @(posedge clk) begin
    req_fired = 1'b0;
    if (!rst) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results still due", cycle_count,
                 due_results.size());
        $display("TEST FAILED");
        $finish;
      end else begin
        if (rsp_ch.valid && rsp_ch.ready) check_result();
        if (req_ch.valid && !req_ch.ready) input_stalls++;
        if (req_ch.valid && req_ch.ready) begin
          req_fired = 1'b1;
          requests_taken++;
          shadow_apply(req_ch.action, req_ch.value);
        end
        // Now and then, switch between gapped traffic and gap-free stretches.
        if ($urandom_range(39) == 0) calm = ~calm;
      end
    end
  end

  // Request driver, on the falling edge. An offered request stays on the
  // channel until it is taken. After that, the gap chosen with it runs out
  // before the next request goes up.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_fired) begin
      // Still waiting for the block to take the current request.
    end else if (send_gap > 0) begin
      req_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_requests.size() > 0) begin
      staged = pending_requests.pop_front();
      req_ch.valid  <= 1'b1;
      req_ch.action <= staged.action;
      req_ch.value  <= staged.value;
      send_gap <= pick_gap();
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Result side, on the falling edge. This process runs the one long
  // hold-off on its own count, and random short and long stalls the rest of
  // the time.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && requests_taken >= HOLD_AT) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (take_gap > 0) begin
      rsp_ch.ready <= 1'b0;
      take_gap <= take_gap - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      take_gap <= pick_gap();
    end
  end

  initial begin
    int target;
    int stretch;
    int roll;
    logic [2:0] act;

    rst = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.action = ACT_PEEK;
    req_ch.value  = '0;
    rsp_ch.ready  = 1'b0;

    // Directed part. Pops, peek and dump are first tried on the empty queue.
    // Then the extreme words go in at both ends, and the first push at the
    // front wraps the front index below zero. A few dumps and pops follow,
    // with both spare codes in between, until the queue is empty again. A
    // dump of a single entry and a pop at the front close this part.
    plan(ACT_POP_FRONT, '0);
    plan(ACT_POP_BACK, '0);
    plan(ACT_PEEK, '0);
    plan(ACT_DUMP, '0);
    plan(ACT_PUSH_FRONT, word_t'(32'h8000_0000));
    plan(ACT_PUSH_BACK, word_t'(32'h7FFF_FFFF));
    plan(ACT_PUSH_FRONT, '1);
    plan(ACT_PUSH_BACK, '0);
    plan(ACT_PUSH_BACK, word_t'(32'h5A5A_A5A5));
    plan(ACT_PEEK, word_t'(32'h1234_5678));
    plan(ACT_DUMP, '0);
    plan(ACT_SPARE_A, pick_word());
    plan(ACT_SPARE_B, pick_word());
    plan(ACT_POP_BACK, '0);
    plan(ACT_POP_FRONT, '0);
    plan(ACT_PEEK, '0);
    plan(ACT_DUMP, '0);
    plan(ACT_POP_BACK, '0);
    plan(ACT_POP_FRONT, '0);
    plan(ACT_POP_FRONT, '0);
    plan(ACT_POP_BACK, '0);
    plan(ACT_DUMP, '0);
    plan(ACT_PUSH_BACK, word_t'(32'hA5A5_5A5A));
    plan(ACT_DUMP, '0);
    plan(ACT_POP_FRONT, '0);

    // Random part. It starts with a burst that fills the queue from both
    // ends. Two pushes then hit the full queue, and a dump streams all the
    // entries. After the burst, each stretch of requests drifts the fill
    // level toward a random target. Small targets are the common case. Dumps,
    // peeks and spare codes are mixed in as noise.
    planned_items = 0;
    while (gen_fill < DEPTH) plan(pick_push(), pick_word());
    plan(ACT_PUSH_FRONT, pick_word());
    plan(ACT_PUSH_BACK, pick_word());
    plan(ACT_DUMP, '0);
    plan(ACT_PEEK, '0);
    plan(ACT_POP_BACK, '0);
    plan(ACT_POP_FRONT, '0);

    while (planned_items < RANDOM_ITEMS) begin
      target  = ($urandom_range(3) == 0) ? $urandom_range(DEPTH) : $urandom_range(8);
      stretch = $urandom_range(15, 5);
      for (int i = 0; i < stretch; i++) begin
        roll = $urandom_range(99);
        if (roll < 4) act = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
        else if (roll < 14) act = ACT_DUMP;
        else if (roll < 24) act = ACT_PEEK;
        else if ((gen_fill < target) == (roll < 80)) act = pick_push();
        else act = pick_pop();
        plan(act, pick_word());
      end
    end

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // First every request has to be taken. After that, every predicted
    // result has to arrive. A quiet stretch at the end catches any result
    // that comes too late.
    while (pending_requests.size() > 0 || req_ch.valid) @(negedge clk);
    while (due_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests: push front/back %0d/%0d, pop front/back %0d/%0d,",
             requests_taken, action_hits[ACT_PUSH_FRONT], action_hits[ACT_PUSH_BACK],
             action_hits[ACT_POP_FRONT], action_hits[ACT_POP_BACK]);
    $display("  peek %0d, dump %0d, spare %0d; %0d results checked.",
             action_hits[ACT_PEEK], action_hits[ACT_DUMP],
             action_hits[ACT_SPARE_A] + action_hits[ACT_SPARE_B], results_seen);
    $display("Pushes on a full queue %0d, accesses to an empty queue %0d,",
             full_pushes, empty_hits);
    $display("  longest dump %0d, request input stalled %0d cycles.",
             deepest_dump, input_stalls);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches found", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
